// ===== design/icmp_prc_pkg.sv =====
// shared types, constants and codes of the icmp probe reply classifier
package icmp_prc_pkg;

    // packet geometry
    localparam int MAX_PACKET_BYTES = 2048;
    localparam int OFFSET_W         = $clog2(MAX_PACKET_BYTES + 1);
    localparam int ICMP_HDR_BYTES   = 8;
    localparam int IHL_SHIFT        = 2;
    localparam int HDR_W            = 6;
    localparam int INNER_W          = 8;
    localparam int CMP_W            = (OFFSET_W > 9) ? OFFSET_W : 9;
    localparam int SRC_FIRST        = 12;
    localparam int SRC_LAST         = 15;

    // icmp message codes
    localparam logic [7:0] TYPE_ECHO_REPLY   = 8'd0;
    localparam logic [7:0] TYPE_TIME_EXCEED  = 8'd11;
    localparam logic [7:0] CODE_TTL_TRANSIT  = 8'd0;

    // configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_IDENTIFIER = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SEQUENCE   = 1'd1;

    typedef enum logic [1:0] {
        MATCH_NONE   = 2'd0,
        MATCH_HOP    = 2'd1,
        MATCH_TARGET = 2'd2
    } t_match_kind;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        t_match_kind match_kind;
        logic [31:0] source_address;
    } t_out_word;

    typedef struct packed {
        logic [15:0] expected_identifier;
        logic [15:0] expected_sequence;
    } t_cfg;

endpackage

// ===== design/icmp_prc_cfg.sv =====
// configuration registers of the classifier
module icmp_prc_cfg (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_wr_en,
    input  logic [icmp_prc_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [icmp_prc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output icmp_prc_pkg::t_cfg                     o_cfg
);
    import icmp_prc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // decode the write
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_IDX_IDENTIFIER: n_cfg.expected_identifier = i_cfg_data;
                CFG_IDX_SEQUENCE:   n_cfg.expected_sequence   = i_cfg_data;
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/icmp_prc_parser.sv =====
// per-packet field capture and match decision, one byte per step
module icmp_prc_parser (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_step,
    input  icmp_prc_pkg::t_in_word  i_word,
    input  icmp_prc_pkg::t_cfg      i_cfg,
    output icmp_prc_pkg::t_out_word o_result
);
    import icmp_prc_pkg::*;

    logic [OFFSET_W-1:0] r_offset,  n_offset;
    logic [HDR_W-1:0]    r_hdr,     n_hdr;
    logic [INNER_W-1:0]  r_inner,   n_inner;
    logic [7:0]          r_type,    n_type;
    logic [7:0]          r_code,    n_code;
    logic [7:0]          r_held,    n_held;
    logic                r_outer_ok, n_outer_ok;
    logic                r_inner_ok, n_inner_ok;
    logic [31:0]         r_src,     n_src;

    logic [7:0]          b;
    logic                active;
    logic [HDR_W-1:0]    ihl_bytes;
    logic [CMP_W-1:0]    off;
    logic [CMP_W-1:0]    h;
    logic [CMP_W-1:0]    s;
    logic [CMP_W-1:0]    seen;
    logic [15:0]         pair;
    t_match_kind         kind;

    assign b         = i_word.packet_byte;
    assign active    = (r_offset < OFFSET_W'(MAX_PACKET_BYTES));
    assign ihl_bytes = HDR_W'(b[3:0]) << IHL_SHIFT;
    assign off       = CMP_W'(r_offset);
    assign pair      = {r_held, b};

    // field capture for the current byte
    always_comb begin
        n_offset   = r_offset;
        n_hdr      = r_hdr;
        n_inner    = r_inner;
        n_type     = r_type;
        n_code     = r_code;
        n_held     = r_held;
        n_outer_ok = r_outer_ok;
        n_inner_ok = r_inner_ok;
        n_src      = r_src;
        h          = CMP_W'(r_hdr);
        s          = CMP_W'(r_inner);
        if (active) begin
            if (r_offset == '0) begin
                n_hdr = ihl_bytes;
            end
            h = CMP_W'(n_hdr);
            if (off >= CMP_W'(SRC_FIRST) && off <= CMP_W'(SRC_LAST)) begin
                n_src = {r_src[23:0], b};
            end
            // outer icmp header
            if (off == h) begin
                n_type = b;
            end
            if (off == h + CMP_W'(1)) begin
                n_code = b;
            end
            if (off == h + CMP_W'(4) || off == h + CMP_W'(6)) begin
                n_held = b;
            end
            if (off == h + CMP_W'(5)) begin
                n_outer_ok = (pair == i_cfg.expected_identifier);
            end
            if (off == h + CMP_W'(7)) begin
                n_outer_ok = r_outer_ok && (pair == i_cfg.expected_sequence);
            end
            // embedded original header
            if (off == h + CMP_W'(ICMP_HDR_BYTES)) begin
                n_inner = INNER_W'(n_hdr) + INNER_W'(ICMP_HDR_BYTES) + INNER_W'(ihl_bytes);
            end
            if (off > h + CMP_W'(ICMP_HDR_BYTES)) begin
                if (off == s + CMP_W'(4) || off == s + CMP_W'(6)) begin
                    n_held = b;
                end
                if (off == s + CMP_W'(5)) begin
                    n_inner_ok = (pair == i_cfg.expected_identifier);
                end
                if (off == s + CMP_W'(7)) begin
                    n_inner_ok = r_inner_ok && (pair == i_cfg.expected_sequence);
                end
            end
            n_offset = r_offset + OFFSET_W'(1);
        end
    end

    // decision on the bytes seen so far, including this one
    always_comb begin
        seen = CMP_W'(n_offset);
        kind = MATCH_NONE;
        if (n_type == TYPE_ECHO_REPLY
                && seen >= CMP_W'(n_hdr) + CMP_W'(ICMP_HDR_BYTES) && n_outer_ok) begin
            kind = MATCH_TARGET;
        end else if (n_type == TYPE_TIME_EXCEED && n_code == CODE_TTL_TRANSIT
                && seen >= CMP_W'(n_hdr) + CMP_W'(ICMP_HDR_BYTES + 1)
                && seen >= CMP_W'(n_inner) + CMP_W'(ICMP_HDR_BYTES) && n_inner_ok) begin
            kind = MATCH_HOP;
        end
    end

    assign o_result.match_kind     = kind;
    assign o_result.source_address = n_src;

    // packet state, cleared after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_word.last_byte)) begin
            r_offset   <= '0;
            r_hdr      <= '0;
            r_inner    <= '0;
            r_type     <= '0;
            r_code     <= '0;
            r_held     <= '0;
            r_outer_ok <= 1'b0;
            r_inner_ok <= 1'b0;
            r_src      <= '0;
        end else if (i_step) begin
            r_offset   <= n_offset;
            r_hdr      <= n_hdr;
            r_inner    <= n_inner;
            r_type     <= n_type;
            r_code     <= n_code;
            r_held     <= n_held;
            r_outer_ok <= n_outer_ok;
            r_inner_ok <= n_inner_ok;
            r_src      <= n_src;
        end
    end

endmodule

// ===== design/icmp_probe_reply_classifier_core.sv =====
// top level: input register, parser, result register and configuration
//
// Classifies received IPv4 packets as replies to traceroute probes.
// Input channel: one packet byte per word (i_in_word.packet_byte), with
// i_in_word.last_byte set on the final byte; a word is taken at a clock
// edge where i_in_valid is high and o_in_stall is low.
// Output channel: one result word per packet, on its last byte, holding
// the match kind (none, time exceeded from a hop, echo reply from the
// target) and the outer source address; taken where o_out_valid is high
// and i_out_stall is low.
// Throughput: one byte per cycle while no last byte waits on the receiver, set
// by the single parse step between the input register and the result register.
// A result is registered as its packet's last byte leaves the input register.
// When the receiver stalls, the result register holds its word; bytes that are
// not the last keep flowing, and a last byte waits in the input register
// until the result register frees up, stalling the sender. Reset clears the
// configuration registers, packet state and both valid flags. Configuration is
// written through i_cfg_wr_en, i_cfg_index and i_cfg_data; the user must do so
// only while no packet is in flight, as the block does not enforce it.
module icmp_probe_reply_classifier_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  icmp_prc_pkg::t_in_word               i_in_word,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output icmp_prc_pkg::t_out_word              o_out_word,
    input  logic                                 i_cfg_wr_en,
    input  logic [icmp_prc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [icmp_prc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import icmp_prc_pkg::*;

    t_cfg      cfg;
    t_out_word result;

    logic      r_in_valid, n_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid, n_out_valid;
    t_out_word r_out_word;

    logic      out_free;
    logic      step;
    logic      in_take;
    logic      finish;

    icmp_prc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    icmp_prc_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_word   (r_in_word),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // flow control: only a last byte needs room in the result register
    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && (!r_in_word.last_byte || out_free);
    assign finish     = step && r_in_word.last_byte;
    assign o_in_stall = r_in_valid && !step;
    assign in_take    = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (step) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (finish) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // input and result words
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word <= i_in_word;
        end
        if (finish) begin
            r_out_word <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // bytes before the last one never hold up the sender
    a_mid_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_in_word.last_byte) |-> !o_in_stall)
        else $error("stall raised on a byte that is not the last");

    // a finished packet always shows a result next cycle
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> o_out_valid)
        else $error("last byte stepped without a result");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !finish)
        else $error("result overwritten while stalled");

    // reset empties both stages
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("valid flag survived reset");

endmodule
